>>> rtl/itss_pkg.sv
// Package for the four-digit seven-segment frame generator.
// Holds the digit struct, segment codes and digit split helpers; no dependencies.
package itss_pkg;

  typedef struct packed {
    logic       neg;
    logic [3:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } itss_digits_t;

  localparam logic [3:0]  CodeBlank = 4'd10;
  localparam logic [3:0]  CodeMinus = 4'd11;
  localparam logic [7:0]  SegBlank  = 8'hFF;
  localparam logic [3:0]  AllDigits = 4'hF;
  localparam logic [3:0]  OnesLine  = 4'b1000;
  localparam logic [2:0]  LastFrame = 3'd7;
  localparam logic [13:0] Thousand  = 14'd1000;
  localparam logic [13:0] Hundred   = 14'd100;
  localparam logic [13:0] Ten       = 14'd10;
  localparam logic signed [15:0] MaxShown = 16'sd9999;
  localparam logic signed [15:0] MinShown = -16'sd999;

  function automatic logic [7:0] seg_of(logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:      seg = 8'hC0;
      4'd1:      seg = 8'hF9;
      4'd2:      seg = 8'hA4;
      4'd3:      seg = 8'hB0;
      4'd4:      seg = 8'h99;
      4'd5:      seg = 8'h92;
      4'd6:      seg = 8'h82;
      4'd7:      seg = 8'hF8;
      4'd8:      seg = 8'h80;
      4'd9:      seg = 8'h90;
      CodeMinus: seg = 8'hBF;
      default:   seg = SegBlank;
    endcase
    return seg;
  endfunction

  function automatic logic [3:0] digit_of(logic [13:0] x, logic [13:0] base);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (x >= 14'(k * base)) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

  function automatic logic [13:0] rem_of(logic [13:0] x, logic [13:0] base, logic [3:0] d);
    logic [13:0] prod;
    prod = 14'({10'd0, d} * base);
    return x - prod;
  endfunction

endpackage

>>> rtl/itss_digits.sv
// Input register and decimal split pipeline: saturate, then peel digits.
// Depends on itss_pkg.
module itss_digits (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          value_i,
  output logic                 dig_valid_o,
  input  logic                 dig_stall_i,
  output itss_pkg::itss_digits_t dig_o
);
  import itss_pkg::*;

  logic               va_q, vb_q, vc_q, vd_q;
  logic               rdy_a, rdy_b, rdy_c, rdy_d;
  logic signed [15:0] value_q;
  logic               neg_b_q, neg_c_q;
  logic [13:0]        mag_b_q;
  logic [3:0]         thou_c_q;
  logic [9:0]         rem_c_q;
  itss_digits_t       dig_q;

  logic signed [15:0] sat;
  logic signed [15:0] negated;
  logic               neg_d;
  logic [13:0]        mag_d;
  logic [3:0]         thou_d;
  logic [13:0]        rem_c_d;
  logic [3:0]         hund_d, tens_d;
  logic [13:0]        rem_h, rem_t;
  itss_digits_t       dig_d;

  assign rdy_d = !vd_q || !dig_stall_i;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign in_stall_o = !rdy_a;

  always_comb begin
    if (value_q > MaxShown) begin
      sat = MaxShown;
    end else if (value_q < MinShown) begin
      sat = MinShown;
    end else begin
      sat = value_q;
    end
    neg_d   = sat[15];
    negated = -sat;
    mag_d   = neg_d ? negated[13:0] : sat[13:0];
  end

  always_comb begin
    thou_d  = digit_of(mag_b_q, Thousand);
    rem_c_d = rem_of(mag_b_q, Thousand, thou_d);
  end

  always_comb begin
    hund_d     = digit_of({4'd0, rem_c_q}, Hundred);
    rem_h      = rem_of({4'd0, rem_c_q}, Hundred, hund_d);
    tens_d     = digit_of(rem_h, Ten);
    rem_t      = rem_of(rem_h, Ten, tens_d);
    dig_d.neg  = neg_c_q;
    dig_d.thou = thou_c_q;
    dig_d.hund = hund_d;
    dig_d.tens = tens_d;
    dig_d.ones = rem_t[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) value_q <= value_i;
    if (rdy_b) begin
      neg_b_q <= neg_d;
      mag_b_q <= mag_d;
    end
    if (rdy_c) begin
      neg_c_q  <= neg_b_q;
      thou_c_q <= thou_d;
      rem_c_q  <= rem_c_d[9:0];
    end
    if (rdy_d) dig_q <= dig_d;
  end

  assign dig_valid_o = vd_q;
  assign dig_o       = dig_q;

`ifndef SYNTHESIS
  a_neg_no_thou: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q && dig_q.neg |-> dig_q.thou == 4'd0)
    else $error("negative value with a thousands digit");
  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |-> dig_q.hund <= 4'd9 && dig_q.tens <= 4'd9 && dig_q.ones <= 4'd9)
    else $error("digit out of decimal range");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> va_q && vb_q && vc_q && vd_q)
    else $error("input stalled with a pipeline bubble");
`endif

endmodule

>>> rtl/itss_frames.sv
// Frame sequencer: encodes digits with blanking and sign, emits eight frames.
// Depends on itss_pkg.
module itss_frames (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   dig_valid_i,
  output logic                   dig_stall_o,
  input  itss_pkg::itss_digits_t dig_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             segment_bits_o,
  output logic [3:0]             digit_lines_o,
  output logic                   last_o
);
  import itss_pkg::*;

  logic       set_valid_q;
  logic [7:0] set_q [4];
  logic [2:0] cnt_q;
  logic       out_valid_q;
  logic [7:0] seg_q;
  logic [3:0] lines_q;
  logic       last_q;

  logic       out_load, take_frame, set_done, set_free, set_load;
  logic       blank_th, blank_h, blank_t, blank_o;
  logic [3:0] code_th, code_h, code_t;
  logic [7:0] set_d [4];

  always_comb begin
    blank_th = dig_i.thou == 4'd0;
    blank_h  = blank_th && dig_i.hund == 4'd0;
    blank_t  = blank_h && dig_i.tens == 4'd0;
    blank_o  = blank_t && dig_i.ones == 4'd0;
    code_th  = blank_th ? ((dig_i.neg && !blank_h) ? CodeMinus : CodeBlank) : dig_i.thou;
    code_h   = blank_h ? ((dig_i.neg && !blank_t) ? CodeMinus : CodeBlank) : dig_i.hund;
    code_t   = blank_t ? ((dig_i.neg && !blank_o) ? CodeMinus : CodeBlank) : dig_i.tens;
    set_d[0] = seg_of(dig_i.ones);
    set_d[1] = seg_of(code_t);
    set_d[2] = seg_of(code_h);
    set_d[3] = seg_of(code_th);
  end

  assign out_load    = !out_valid_q || !out_stall_i;
  assign take_frame  = set_valid_q && out_load;
  assign set_done    = take_frame && cnt_q == LastFrame;
  assign set_free    = !set_valid_q || set_done;
  assign set_load    = set_free && dig_valid_i;
  assign dig_stall_o = !set_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (set_free) set_valid_q <= dig_valid_i;
      if (set_load) begin
        cnt_q <= 3'd0;
      end else if (take_frame) begin
        cnt_q <= cnt_q + 3'd1;
      end
      if (out_load) out_valid_q <= set_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_load) begin
      for (int i = 0; i < 4; i++) set_q[i] <= set_d[i];
    end
    if (take_frame) begin
      if (cnt_q[0]) begin
        seg_q   <= SegBlank;
        lines_q <= AllDigits;
      end else begin
        seg_q   <= set_q[cnt_q[2:1]];
        lines_q <= OnesLine >> cnt_q[2:1];
      end
      last_q <= cnt_q == LastFrame;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segment_bits_o = seg_q;
  assign digit_lines_o  = lines_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_last_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> segment_bits_o == SegBlank && digit_lines_o == AllDigits)
    else $error("last frame is not a blank frame");
  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && digit_lines_o != AllDigits |-> $onehot(digit_lines_o) && !last_o)
    else $error("digit frame select not one-hot");
  a_set_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_load |=> set_valid_q && cnt_q == 3'd0)
    else $error("new digit set did not restart the frame count");
`endif

endmodule

>>> rtl/int_to_four_digit_seven_segment_top.sv
// Four-digit seven-segment frame generator, top level.
// An accepted value passes the input, magnitude, thousands, digit, digit-set and
// frame registers to its first frame. 8 frames per value, one per cycle unless
// out_stall_i holds; the single output paces values, taken as old frames drain.
// Reset (rst_ni, async active low) clears valid and sequencer state only.
module int_to_four_digit_seven_segment_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segment_bits_o,
  output logic [3:0]  digit_lines_o,
  output logic        last_o
);
  import itss_pkg::*;

  logic         dig_valid;
  logic         dig_stall;
  itss_digits_t digits;

  itss_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .dig_valid_o (dig_valid),
    .dig_stall_i (dig_stall),
    .dig_o       (digits)
  );

  itss_frames u_frames (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dig_valid_i    (dig_valid),
    .dig_stall_o    (dig_stall),
    .dig_i          (digits),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segment_bits_o (segment_bits_o),
    .digit_lines_o  (digit_lines_o),
    .last_o         (last_o)
  );

endmodule
